>>> hw/rtl/machine_mode_csr_unit_macros.svh
// Assertion macros for the machine-mode CSR unit
`ifndef MACHINE_MODE_CSR_UNIT_MACROS_SVH
`define MACHINE_MODE_CSR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MCSR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MCSR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MCSR_ASSERT(label, clk, rst_n, prop)
`define MCSR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/mcsr_pkg.sv
// Package: types, constants and address codes for the CSR unit
package mcsr_pkg;

  localparam int PmpCfgCount  = 16;
  localparam int PmpAddrCount = 64;
  localparam int IntLines     = 16;
  localparam int PmpCfgW      = (PmpCfgCount > 1) ? $clog2(PmpCfgCount) : 1;
  localparam int PmpAddrW     = (PmpAddrCount > 1) ? $clog2(PmpAddrCount) : 1;
  localparam int IntIdxW      = (IntLines > 1) ? $clog2(IntLines) : 1;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_TRAP  = 3'd2;
  localparam logic [2:0] ACT_MRET  = 3'd3;
  localparam logic [2:0] ACT_INTR  = 3'd4;

  localparam logic [11:0] A_FFLAGS   = 12'h001;
  localparam logic [11:0] A_FRM      = 12'h002;
  localparam logic [11:0] A_FCSR     = 12'h003;
  localparam logic [11:0] A_SSTATUS  = 12'h100;
  localparam logic [11:0] A_STVEC    = 12'h105;
  localparam logic [11:0] A_SSCRATCH = 12'h140;
  localparam logic [11:0] A_SEPC     = 12'h141;
  localparam logic [11:0] A_SCAUSE   = 12'h142;
  localparam logic [11:0] A_STVAL    = 12'h143;
  localparam logic [11:0] A_SIP      = 12'h144;
  localparam logic [11:0] A_SATP     = 12'h180;
  localparam logic [11:0] A_MSTATUS  = 12'h300;
  localparam logic [11:0] A_MISA     = 12'h301;
  localparam logic [11:0] A_MEDELEG  = 12'h302;
  localparam logic [11:0] A_MIDELEG  = 12'h303;
  localparam logic [11:0] A_MIE      = 12'h304;
  localparam logic [11:0] A_MTVEC    = 12'h305;
  localparam logic [11:0] A_MCOUNTEN = 12'h306;
  localparam logic [11:0] A_MCOUNTIN = 12'h320;
  localparam logic [11:0] A_MSCRATCH = 12'h340;
  localparam logic [11:0] A_MEPC     = 12'h341;
  localparam logic [11:0] A_MCAUSE   = 12'h342;
  localparam logic [11:0] A_MTVAL    = 12'h343;
  localparam logic [11:0] A_MIP      = 12'h344;
  localparam logic [11:0] A_PMPCFG0  = 12'h3A0;
  localparam logic [11:0] A_PMPCFGL  = 12'h3AF;
  localparam logic [11:0] A_PMPADDR0 = 12'h3B0;
  localparam logic [11:0] A_PMPADDRL = 12'h3EF;
  localparam logic [11:0] A_TSELECT  = 12'h7A0;
  localparam logic [11:0] A_TDATA1   = 12'h7A1;
  localparam logic [11:0] A_TDATA2   = 12'h7A2;
  localparam logic [11:0] A_TDATA3   = 12'h7A3;
  localparam logic [11:0] A_TCONTROL = 12'h7A5;
  localparam logic [11:0] A_MCYCLE   = 12'hB00;
  localparam logic [11:0] A_MINSTRET = 12'hB02;
  localparam logic [11:0] A_CYCLE    = 12'hC00;
  localparam logic [11:0] A_TIME     = 12'hC01;
  localparam logic [11:0] A_INSTRET  = 12'hC02;
  localparam logic [11:0] A_MVENDOR  = 12'hF11;
  localparam logic [11:0] A_MARCH    = 12'hF12;
  localparam logic [11:0] A_MIMP     = 12'hF13;
  localparam logic [11:0] A_MHART    = 12'hF14;

  localparam logic [63:0] INT_BIT     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ST_MIE      = 64'h8;
  localparam logic [63:0] ST_MPIE     = 64'h80;
  localparam logic [63:0] ST_MPP      = 64'h1800;
  localparam logic [63:0] ST_UXL_MASK = 64'h3_0000_0000;
  localparam logic [63:0] ST_UXL_VAL  = 64'h2_0000_0000;
  localparam logic [63:0] ISA_MXL64   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ISA_C       = 64'h4;
  localparam logic [63:0] ISA_I       = 64'h100;
  localparam logic [25:0] EXT_RESET   = 26'd4397;
  localparam logic [7:0]  TCTL_MASK   = 8'h88;
  localparam logic [1:0]  PRIV_M      = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] csr_addr;
    logic [63:0] write_data;
    logic [63:0] current_pc;
    logic [63:0] following_pc;
    logic [63:0] trap_cause;
    logic [63:0] trap_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        illegal;
    logic        redirect;
    logic [63:0] redirect_pc;
    logic        interrupt_taken;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the input transaction
    logic execute;  // update state and form the result
  } cmd_t;

endpackage

>>> hw/rtl/mcsr_ctrl.sv
// Controller: sequences capture, execute and result hand-off
module mcsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mcsr_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  // a new transaction may enter while the previous result is being taken
  assign in_ready  = (state_r == S_IDLE) || (state_r == S_DONE && out_ready);
  assign out_valid = (state_r == S_DONE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: begin
        if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> hw/rtl/mcsr_dp.sv
// Datapath: CSR state, address decode, WARL masking, trap and mret logic
module mcsr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mcsr_pkg::cmd_t      cmd,
  input  mcsr_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [25:0]         cfg_wdata,
  output mcsr_pkg::out_item_t out_item
);

  mcsr_pkg::in_item_t  it_r;
  mcsr_pkg::out_item_t res_r, res_nxt;

  logic [25:0] ext_r;
  logic [63:0] status_r, isa_r, medeleg_r, mideleg_r, mie_r, mip_r, mtvec_r;
  logic [63:0] mcounten_r, mcountin_r, mscratch_r, mepc_r, mcause_r, mtval_r;
  logic [63:0] stvec_r, sscratch_r, sepc_r, scause_r, stval_r, satp_r;
  logic [63:0] tselect_r, cycle_r, instret_r;
  logic [4:0]  fflags_r;
  logic [2:0]  frm_r;
  logic [7:0]  tctl_r;
  logic [1:0]  touched_r;
  logic [1:0]  priv_r;
  logic [63:0] pmpcfg_r  [mcsr_pkg::PmpCfgCount];
  logic [63:0] pmpaddr_r [mcsr_pkg::PmpAddrCount];
  // pmpaddr entries read as zero until first written
  logic [mcsr_pkg::PmpAddrCount-1:0] pmpaddr_vld_r;
  logic [63:0] pmpaddr_rd_r;
  logic        pmpaddr_hit_r;
  logic        pmpaddr_we;

  logic [11:0] a;
  logic [63:0] wd;
  logic [11:0] cfg_off, addr_off, in_addr_off;
  logic        is_cfg, is_addr;
  logic [mcsr_pkg::PmpCfgW-1:0]  cfg_idx;
  logic [mcsr_pkg::PmpAddrW-1:0] addr_idx, in_addr_idx;
  logic [63:0] rd;
  logic        rd_ok, wr_ok;
  logic [63:0] mpp_fix, isa_new;
  logic [63:0] pend;
  logic        pend_any;
  logic [mcsr_pkg::IntIdxW-1:0] pend_idx;
  logic        do_trap;
  logic [63:0] t_cause, t_pc, t_val, t_base, t_status, mret_status, mret_pc;

  assign a  = it_r.csr_addr;
  assign wd = it_r.write_data;
  assign cfg_off  = a - mcsr_pkg::A_PMPCFG0;
  assign addr_off = a - mcsr_pkg::A_PMPADDR0;
  assign is_cfg  = a >= mcsr_pkg::A_PMPCFG0 && a <= mcsr_pkg::A_PMPCFGL &&
                   cfg_off < 12'(mcsr_pkg::PmpCfgCount);
  assign is_addr = a >= mcsr_pkg::A_PMPADDR0 && a <= mcsr_pkg::A_PMPADDRL &&
                   addr_off < 12'(mcsr_pkg::PmpAddrCount);
  assign cfg_idx  = cfg_off[mcsr_pkg::PmpCfgW-1:0];
  assign addr_idx = addr_off[mcsr_pkg::PmpAddrW-1:0];
  // pmpaddr is read at capture, ahead of the execute cycle
  assign in_addr_off = in_item.csr_addr - mcsr_pkg::A_PMPADDR0;
  assign in_addr_idx = in_addr_off[mcsr_pkg::PmpAddrW-1:0];

  // read mux
  always_comb begin
    rd = '0;
    rd_ok = 1'b1;
    unique case (a)
      mcsr_pkg::A_MCYCLE, mcsr_pkg::A_CYCLE, mcsr_pkg::A_TIME: rd = cycle_r;
      mcsr_pkg::A_MINSTRET, mcsr_pkg::A_INSTRET: rd = instret_r;
      mcsr_pkg::A_FFLAGS:   rd = {59'd0, fflags_r};
      mcsr_pkg::A_FRM:      rd = {61'd0, frm_r};
      mcsr_pkg::A_FCSR:     rd = {56'd0, frm_r, fflags_r};
      mcsr_pkg::A_SSTATUS:  rd = status_r | mcsr_pkg::ST_UXL_VAL;
      mcsr_pkg::A_STVEC:    rd = stvec_r;
      mcsr_pkg::A_SSCRATCH: rd = sscratch_r;
      mcsr_pkg::A_SEPC:     rd = sepc_r;
      mcsr_pkg::A_SCAUSE:   rd = scause_r;
      mcsr_pkg::A_STVAL:    rd = stval_r;
      mcsr_pkg::A_SIP, mcsr_pkg::A_MIP: rd = mip_r;
      mcsr_pkg::A_SATP:     rd = satp_r;
      mcsr_pkg::A_MSTATUS:  rd = status_r;
      mcsr_pkg::A_MISA:     rd = isa_r;
      mcsr_pkg::A_MEDELEG:  rd = medeleg_r;
      mcsr_pkg::A_MIDELEG:  rd = mideleg_r;
      mcsr_pkg::A_MIE:      rd = mie_r;
      mcsr_pkg::A_MTVEC:    rd = mtvec_r;
      mcsr_pkg::A_MCOUNTEN: rd = mcounten_r;
      mcsr_pkg::A_MCOUNTIN: rd = mcountin_r;
      mcsr_pkg::A_MSCRATCH: rd = mscratch_r;
      mcsr_pkg::A_MEPC:     rd = mepc_r;
      mcsr_pkg::A_MCAUSE:   rd = mcause_r;
      mcsr_pkg::A_MTVAL:    rd = mtval_r;
      mcsr_pkg::A_TSELECT:  rd = tselect_r;
      mcsr_pkg::A_TDATA1, mcsr_pkg::A_TDATA2, mcsr_pkg::A_TDATA3: rd = '0;
      mcsr_pkg::A_TCONTROL: rd = {56'd0, tctl_r};
      mcsr_pkg::A_MVENDOR, mcsr_pkg::A_MARCH, mcsr_pkg::A_MIMP,
      mcsr_pkg::A_MHART: rd = '0;
      default: begin
        if (is_cfg)       rd = pmpcfg_r[cfg_idx];
        else if (is_addr) rd = pmpaddr_hit_r ? pmpaddr_rd_r : '0;
        else              rd_ok = 1'b0;
      end
    endcase
  end

  // read-only ids and user counters refuse writes
  assign wr_ok = rd_ok && a != mcsr_pkg::A_CYCLE && a != mcsr_pkg::A_TIME &&
                 a != mcsr_pkg::A_INSTRET && a != mcsr_pkg::A_MVENDOR &&
                 a != mcsr_pkg::A_MARCH && a != mcsr_pkg::A_MIMP &&
                 a != mcsr_pkg::A_MHART;

  assign pmpaddr_we = cmd.execute && it_r.action == mcsr_pkg::ACT_WRITE && wr_ok && is_addr;

  always_comb begin
    mpp_fix = wd;
    if ((wd & mcsr_pkg::ST_MPP) != '0 && (wd & mcsr_pkg::ST_MPP) != mcsr_pkg::ST_MPP)
      mpp_fix = wd & ~mcsr_pkg::ST_MPP;
    isa_new = mcsr_pkg::ISA_MXL64 | (wd & {38'd0, ext_r}) | mcsr_pkg::ISA_I;
    if ((isa_r & mcsr_pkg::ISA_C) != '0 && (isa_new & mcsr_pkg::ISA_C) == '0 &&
        it_r.following_pc[1:0] != 2'd0)
      isa_new = isa_new | mcsr_pkg::ISA_C;
  end

  // highest enabled pending line
  always_comb begin
    pend = mip_r & mie_r;
    pend_any = 1'b0;
    pend_idx = '0;
    for (int i = 0; i < mcsr_pkg::IntLines; i++) begin
      if (pend[i]) begin
        pend_any = 1'b1;
        pend_idx = mcsr_pkg::IntIdxW'(i);
      end
    end
  end

  always_comb begin
    do_trap = 1'b0;
    t_cause = it_r.trap_cause;
    t_val   = it_r.trap_value;
    t_pc    = it_r.current_pc;
    if (it_r.action == mcsr_pkg::ACT_TRAP) do_trap = 1'b1;
    if (it_r.action == mcsr_pkg::ACT_INTR && status_r[3] && pend_any) begin
      do_trap = 1'b1;
      t_cause = mcsr_pkg::INT_BIT | 64'(pend_idx);
      t_val   = '0;
    end
    t_base = mtvec_r & ~64'd3;
    if (mtvec_r[1:0] == 2'd1 && t_cause[63])
      t_base = t_base + {31'd0, t_cause[30:0], 2'b00};
    t_status = (status_r & ~(mcsr_pkg::ST_MPIE | mcsr_pkg::ST_MIE)) |
               (status_r[3] ? mcsr_pkg::ST_MPIE : '0) | mcsr_pkg::ST_MPP;
    mret_status = ((status_r & ~(mcsr_pkg::ST_MIE | mcsr_pkg::ST_MPP)) |
                   (status_r[7] ? mcsr_pkg::ST_MIE : '0)) | mcsr_pkg::ST_MPIE;
    mret_pc = mepc_r & ~64'd1;
    if (!isa_r[2]) mret_pc = mret_pc & ~64'd2;
  end

  always_comb begin
    res_nxt = '0;
    unique case (it_r.action)
      mcsr_pkg::ACT_READ: begin
        res_nxt.read_data = rd_ok ? rd : '0;
        res_nxt.illegal   = !rd_ok;
      end
      mcsr_pkg::ACT_WRITE: res_nxt.illegal = !wr_ok;
      mcsr_pkg::ACT_TRAP: begin
        res_nxt.redirect = 1'b1;
        res_nxt.redirect_pc = t_base;
      end
      mcsr_pkg::ACT_MRET: begin
        res_nxt.redirect = 1'b1;
        res_nxt.redirect_pc = mret_pc;
      end
      mcsr_pkg::ACT_INTR: begin
        res_nxt.redirect = do_trap;
        res_nxt.redirect_pc = do_trap ? t_base : '0;
        res_nxt.interrupt_taken = do_trap;
      end
      default: res_nxt = '0;
    endcase
  end

  assign out_item = res_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_r <= in_item;
      pmpaddr_hit_r <= pmpaddr_vld_r[in_addr_idx];
    end
    if (cmd.execute) res_r <= res_nxt;
  end

  // capture and execute never share a cycle, so the read sees the last write
  always_ff @(posedge clk) begin
    if (pmpaddr_we) pmpaddr_r[addr_idx] <= wd;
    if (cmd.capture) pmpaddr_rd_r <= pmpaddr_r[in_addr_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= mcsr_pkg::EXT_RESET;
      status_r <= mcsr_pkg::ST_UXL_VAL;
      isa_r <= mcsr_pkg::ISA_MXL64 | {38'd0, mcsr_pkg::EXT_RESET};
      medeleg_r <= '0; mideleg_r <= '0; mie_r <= '0; mip_r <= '0; mtvec_r <= '0;
      mcounten_r <= '0; mcountin_r <= '0; mscratch_r <= '0; mepc_r <= '0;
      mcause_r <= '0; mtval_r <= '0; stvec_r <= '0; sscratch_r <= '0;
      sepc_r <= '0; scause_r <= '0; stval_r <= '0; satp_r <= '0;
      tselect_r <= '0; cycle_r <= '0; instret_r <= '0;
      fflags_r <= '0; frm_r <= '0; tctl_r <= '0; touched_r <= '0;
      priv_r <= mcsr_pkg::PRIV_M;
      pmpaddr_vld_r <= '0;
      for (int i = 0; i < mcsr_pkg::PmpCfgCount; i++) pmpcfg_r[i] <= '0;
    end else begin
      if (cfg_we) ext_r <= cfg_wdata;
      if (pmpaddr_we) pmpaddr_vld_r[addr_idx] <= 1'b1;
      if (cmd.execute) begin
        if (do_trap) begin
          mepc_r <= t_pc;
          mcause_r <= t_cause;
          mtval_r <= t_val;
          status_r <= t_status;
        end
        if (it_r.action == mcsr_pkg::ACT_MRET) begin
          status_r <= mret_status;
          priv_r <= mcsr_pkg::PRIV_M;
        end
        if (it_r.action == mcsr_pkg::ACT_WRITE && wr_ok) begin
          unique case (a)
            mcsr_pkg::A_MCYCLE:   begin cycle_r <= wd; touched_r <= 2'd1; end
            mcsr_pkg::A_MINSTRET: begin instret_r <= wd; touched_r <= 2'd2; end
            mcsr_pkg::A_FFLAGS:   fflags_r <= wd[4:0];
            mcsr_pkg::A_FRM:      frm_r <= wd[2:0];
            mcsr_pkg::A_FCSR:     begin frm_r <= wd[7:5]; fflags_r <= wd[4:0]; end
            mcsr_pkg::A_SSTATUS:
              status_r <= (wd & ~mcsr_pkg::ST_UXL_MASK) | mcsr_pkg::ST_UXL_VAL;
            mcsr_pkg::A_STVEC:    stvec_r <= wd & ~64'd3;
            mcsr_pkg::A_SSCRATCH: sscratch_r <= wd;
            mcsr_pkg::A_SEPC:     sepc_r <= wd & ~64'd1;
            mcsr_pkg::A_SCAUSE:   scause_r <= wd;
            mcsr_pkg::A_STVAL:    stval_r <= wd;
            mcsr_pkg::A_SIP, mcsr_pkg::A_MIP: mip_r <= wd;
            mcsr_pkg::A_SATP:     satp_r <= wd;
            mcsr_pkg::A_MSTATUS:
              status_r <= (mpp_fix & ~mcsr_pkg::ST_UXL_MASK) | mcsr_pkg::ST_UXL_VAL;
            mcsr_pkg::A_MISA:     isa_r <= isa_new;
            mcsr_pkg::A_MEDELEG:  medeleg_r <= wd;
            mcsr_pkg::A_MIDELEG:  mideleg_r <= wd;
            mcsr_pkg::A_MIE:      mie_r <= wd;
            mcsr_pkg::A_MTVEC:    mtvec_r <= wd & ~64'd2;
            mcsr_pkg::A_MCOUNTEN: mcounten_r <= wd;
            mcsr_pkg::A_MCOUNTIN: mcountin_r <= wd;
            mcsr_pkg::A_MSCRATCH: mscratch_r <= wd;
            mcsr_pkg::A_MEPC:     mepc_r <= wd & ~64'd1;
            mcsr_pkg::A_MCAUSE:   mcause_r <= wd;
            mcsr_pkg::A_MTVAL:    mtval_r <= wd;
            mcsr_pkg::A_TSELECT:  tselect_r <= wd;
            mcsr_pkg::A_TCONTROL: tctl_r <= wd[7:0] & mcsr_pkg::TCTL_MASK;
            default: begin
              if (is_cfg) pmpcfg_r[cfg_idx] <= wd;
            end
          endcase
        end
      end
    end
  end

endmodule

>>> hw/rtl/machine_mode_csr_unit.sv
// Top level of the RV64 machine-mode CSR unit
// Each transaction (CSR read, CSR write, trap, mret or interrupt check) goes
// from acceptance to result via a capture step, which registers the input,
// and an execute step, which decodes the address and updates the CSR state.
// The next transaction is taken in the cycle its predecessor's result is taken,
// so none enters before the previous result is taken (the controller's
// capture/execute sequence). The result register holds until out_ready.
`include "machine_mode_csr_unit_macros.svh"
module machine_mode_csr_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcsr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcsr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [25:0]         cfg_wdata
);

  mcsr_pkg::cmd_t cmd;

  mcsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  mcsr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_item(out_data)
  );

  `MCSR_ASSERT(a_exec_after_capture, clk, rst_n, cmd.capture |=> cmd.execute)
  `MCSR_ASSERT(a_result_after_exec, clk, rst_n, cmd.execute |=> out_valid)
  `MCSR_ASSERT(a_taken_redirects, clk, rst_n,
    out_valid && out_data.interrupt_taken |-> out_data.redirect)
  `MCSR_ASSERT(a_no_exec_with_result, clk, rst_n, !(cmd.execute && out_valid))

endmodule
